// File: design/gtpr_pkg.sv
// Shared types, constants and tile side tables for the grid tile path reachability block.
`timescale 1ns / 1ps

package gtpr_pkg;

    localparam int GTPR_MAX_ROWS    = 64;
    localparam int GTPR_MAX_COLUMNS = 64;
    localparam int CFG_DATA_W       = 7;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Side bits of a tile.
    localparam logic [3:0] SIDE_LEFT  = 4'b0001;
    localparam logic [3:0] SIDE_RIGHT = 4'b0010;
    localparam logic [3:0] SIDE_UP    = 4'b0100;
    localparam logic [3:0] SIDE_DOWN  = 4'b1000;

    typedef enum logic [2:0] {
        TILE_NONE       = 3'd0,
        TILE_LEFT_RIGHT = 3'd1,
        TILE_UP_DOWN    = 3'd2,
        TILE_LEFT_DOWN  = 3'd3,
        TILE_RIGHT_DOWN = 3'd4,
        TILE_LEFT_UP    = 3'd5,
        TILE_RIGHT_UP   = 3'd6,
        TILE_BLANK      = 3'd7
    } t_tile;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_INIT,
        ST_POP,
        ST_FETCH,
        ST_HERE,
        ST_NB_ADDR,
        ST_NB_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic init;
        logic pop;
        logic fetch;
        logic here;
        logic nb_addr;
        logic nb_check;
        logic dir_next;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_beat;
        logic clear_done;
        logic queue_empty;
        logic nb_ok;
        logic dir_last;
        logic slot_free;
    } t_dp_status;

    function automatic logic [3:0] tile_sides(input logic [2:0] code);
        logic [3:0] sides;
        case (t_tile'(code))
            TILE_LEFT_RIGHT: sides = SIDE_LEFT | SIDE_RIGHT;
            TILE_UP_DOWN:    sides = SIDE_UP | SIDE_DOWN;
            TILE_LEFT_DOWN:  sides = SIDE_LEFT | SIDE_DOWN;
            TILE_RIGHT_DOWN: sides = SIDE_RIGHT | SIDE_DOWN;
            TILE_LEFT_UP:    sides = SIDE_LEFT | SIDE_UP;
            TILE_RIGHT_UP:   sides = SIDE_RIGHT | SIDE_UP;
            default:         sides = 4'b0000;
        endcase
        return sides;
    endfunction

    function automatic logic [3:0] exit_mask(input t_dir dir);
        logic [3:0] m;
        case (dir)
            DIR_UP:    m = SIDE_UP;
            DIR_DOWN:  m = SIDE_DOWN;
            DIR_LEFT:  m = SIDE_LEFT;
            DIR_RIGHT: m = SIDE_RIGHT;
            default:   m = 4'b0000;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] entry_mask(input t_dir dir);
        logic [3:0] m;
        case (dir)
            DIR_UP:    m = SIDE_DOWN;
            DIR_DOWN:  m = SIDE_UP;
            DIR_LEFT:  m = SIDE_RIGHT;
            DIR_RIGHT: m = SIDE_LEFT;
            default:   m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

// File: design/gtpr_ctrl.sv
// Controller state machine sequencing grid load, visited clear and flood fill search.
`timescale 1ns / 1ps

module gtpr_ctrl
    import gtpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_status.last_beat) n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (i_status.clear_done) n_state = ST_INIT;
            end
            ST_INIT: begin
                n_state = ST_POP;
            end
            ST_POP: begin
                n_state = i_status.queue_empty ? ST_FINISH : ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_HERE;
            end
            ST_HERE: begin
                n_state = ST_NB_ADDR;
            end
            ST_NB_ADDR: begin
                if (i_status.nb_ok) begin
                    n_state = ST_NB_CHECK;
                end else if (i_status.dir_last) begin
                    n_state = ST_POP;
                end
            end
            ST_NB_CHECK: begin
                n_state = i_status.dir_last ? ST_POP : ST_NB_ADDR;
            end
            ST_FINISH: begin
                if (i_status.slot_free) n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LOAD:     o_cmd.load = 1'b1;
            ST_CLEAR:    o_cmd.clear = 1'b1;
            ST_INIT:     o_cmd.init = 1'b1;
            ST_POP:      o_cmd.pop = !i_status.queue_empty;
            ST_FETCH:    o_cmd.fetch = 1'b1;
            ST_HERE:     o_cmd.here = 1'b1;
            ST_NB_ADDR: begin
                o_cmd.nb_addr  = i_status.nb_ok;
                o_cmd.dir_next = !i_status.nb_ok && !i_status.dir_last;
            end
            ST_NB_CHECK: begin
                o_cmd.nb_check = 1'b1;
                o_cmd.dir_next = !i_status.dir_last;
            end
            ST_FINISH:   o_cmd.out_load = i_status.slot_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// File: design/gtpr_datapath.sv
// Datapath: configuration, tile store, visited map, cell queue and result register.
`timescale 1ns / 1ps

module gtpr_datapath
    import gtpr_pkg::*;
#(
    parameter int MAX_ROWS    = GTPR_MAX_ROWS,
    parameter int MAX_COLUMNS = GTPR_MAX_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [2:0]            i_tile_code,
    input  logic                  i_last_cell,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_path_exists
);

    localparam int CAP = MAX_ROWS * MAX_COLUMNS;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int ACW = $clog2(CAP + 1);
    localparam int QW  = AW + RW + CW;
    localparam logic [ACW-1:0] CAP_L = ACW'(CAP);

    // Configuration and effective grid size.
    logic [CFG_DATA_W-1:0] r_row_cfg;
    logic [CFG_DATA_W-1:0] r_col_cfg;
    logic [RCW-1:0]        rows_eff;
    logic [CCW-1:0]        cols_eff;
    logic [RCW-1:0]        r_rows;
    logic [CCW-1:0]        r_cols;
    logic [ACW-1:0]        r_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cfg <= CFG_DATA_W'(1);
            r_col_cfg <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:    r_row_cfg <= i_cfg_data;
                CFG_COLUMN_COUNT: r_col_cfg <= i_cfg_data;
                default:          r_row_cfg <= r_row_cfg;
            endcase
        end
    end

    always_comb begin
        if (r_row_cfg == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(r_row_cfg) > MAX_ROWS) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(r_row_cfg);
        end
        if (r_col_cfg == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_col_cfg) > MAX_COLUMNS) begin
            cols_eff = CCW'(MAX_COLUMNS);
        end else begin
            cols_eff = CCW'(r_col_cfg);
        end
    end

    // Size is registered so that the product does not sit on a search path.
    always_ff @(posedge i_clk) begin
        r_rows  <= rows_eff;
        r_cols  <= cols_eff;
        r_cells <= ACW'(rows_eff) * ACW'(cols_eff);
    end

    // Loading.
    logic           accept;
    logic [ACW-1:0] r_load;

    assign accept = i_cmd.load && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
        end else if (accept) begin
            if (i_last_cell) begin
                r_load <= '0;
            end else if (r_load < CAP_L) begin
                r_load <= r_load + ACW'(1);
            end
        end
    end

    // Search registers.
    logic [ACW-1:0] r_clr;
    logic [ACW-1:0] r_head;
    logic [ACW-1:0] r_tail;
    logic [AW-1:0]  r_cur_idx;
    logic [RW-1:0]  r_cur_r;
    logic [CW-1:0]  r_cur_c;
    logic [3:0]     r_here;
    t_dir           r_dir;
    logic [AW-1:0]  r_nb_idx;
    logic [RW-1:0]  r_nb_r;
    logic [CW-1:0]  r_nb_c;
    logic           r_found;

    // Memories and their registered read data.
    logic [2:0]    tile_mem [CAP];
    logic          vis_mem  [CAP];
    logic [QW-1:0] queue_mem[CAP];
    logic [2:0]    tile_rd;
    logic          vis_rd;
    logic [QW-1:0] q_rd;

    // Neighbour of the current cell in the current direction.
    logic          nb_in;
    logic [AW-1:0] nb_idx;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic          nb_ok;

    always_comb begin
        nb_in  = 1'b0;
        nb_idx = r_cur_idx;
        nb_r   = r_cur_r;
        nb_c   = r_cur_c;
        case (r_dir)
            DIR_UP: begin
                nb_in  = (r_cur_r != '0);
                nb_idx = r_cur_idx - AW'(r_cols);
                nb_r   = r_cur_r - RW'(1);
            end
            DIR_DOWN: begin
                nb_in  = ((RCW'(r_cur_r) + RCW'(1)) < r_rows);
                nb_idx = r_cur_idx + AW'(r_cols);
                nb_r   = r_cur_r + RW'(1);
            end
            DIR_LEFT: begin
                nb_in  = (r_cur_c != '0);
                nb_idx = r_cur_idx - AW'(1);
                nb_c   = r_cur_c - CW'(1);
            end
            DIR_RIGHT: begin
                nb_in  = ((CCW'(r_cur_c) + CCW'(1)) < r_cols);
                nb_idx = r_cur_idx + AW'(1);
                nb_c   = r_cur_c + CW'(1);
            end
            default: nb_in = 1'b0;
        endcase
        nb_ok = nb_in && ((r_here & exit_mask(r_dir)) != 4'b0000);
    end

    logic nb_take;
    logic nb_goal;

    assign nb_take = i_cmd.nb_check && !vis_rd &&
                     ((tile_sides(tile_rd) & entry_mask(r_dir)) != 4'b0000);
    assign nb_goal = ((RCW'(r_nb_r) + RCW'(1)) == r_rows) &&
                     ((CCW'(r_nb_c) + CCW'(1)) == r_cols);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_dir   <= DIR_UP;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + ACW'(1);
            if (i_cmd.init) begin
                r_clr   <= '0;
                r_head  <= '0;
                r_tail  <= ACW'(1);
                r_found <= (r_rows == RCW'(1)) && (r_cols == CCW'(1));
            end
            if (i_cmd.pop) r_head <= r_head + ACW'(1);
            if (nb_take) begin
                r_tail <= r_tail + ACW'(1);
                if (nb_goal) r_found <= 1'b1;
            end
            if (i_cmd.here) begin
                r_dir <= DIR_UP;
            end else if (i_cmd.dir_next) begin
                r_dir <= t_dir'(r_dir + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            {r_cur_idx, r_cur_r, r_cur_c} <= q_rd;
        end
        if (i_cmd.here) begin
            r_here <= tile_sides(tile_rd);
        end
        if (i_cmd.nb_addr) begin
            r_nb_idx <= nb_idx;
            r_nb_r   <= nb_r;
            r_nb_c   <= nb_c;
        end
    end

    // Tile store: written while loading, read at the popped cell or a neighbour.
    logic [AW-1:0] tile_raddr;

    assign tile_raddr = i_cmd.fetch ? q_rd[QW-1 -: AW] : nb_idx;

    always_ff @(posedge i_clk) begin
        if (accept && (r_load < CAP_L)) begin
            tile_mem[r_load[AW-1:0]] <= i_tile_code;
        end
        tile_rd <= tile_mem[tile_raddr];
    end

    // Visited map: cleared by a sweep at the start of each search.
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic          vis_wdata;

    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = r_nb_idx;
        vis_wdata = 1'b1;
        if (i_cmd.clear) begin
            vis_we    = 1'b1;
            vis_waddr = r_clr[AW-1:0];
            vis_wdata = 1'b0;
        end else if (i_cmd.init) begin
            vis_we    = 1'b1;
            vis_waddr = '0;
        end else if (nb_take) begin
            vis_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
        vis_rd <= vis_mem[nb_idx];
    end

    // Cell queue: each entry holds the cell index, its row and its column.
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [QW-1:0] q_wdata;

    always_comb begin
        q_we    = i_cmd.init || nb_take;
        q_waddr = i_cmd.init ? '0 : r_tail[AW-1:0];
        q_wdata = i_cmd.init ? '0 : {r_nb_idx, r_nb_r, r_nb_c};
    end

    always_ff @(posedge i_clk) begin
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        q_rd <= queue_mem[r_head[AW-1:0]];
    end

    // Result register.
    logic r_out_valid;
    logic r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out_data <= r_found;
    end

    assign o_out_valid   = r_out_valid;
    assign o_path_exists = r_out_data;

    assign o_status.last_beat   = accept && i_last_cell;
    assign o_status.clear_done  = (r_clr == (r_cells - ACW'(1)));
    assign o_status.queue_empty = (r_head == r_tail);
    assign o_status.nb_ok       = nb_ok;
    assign o_status.dir_last    = (r_dir == DIR_RIGHT);
    assign o_status.slot_free   = !r_out_valid || i_out_ready;

endmodule

// File: design/grid_tile_path_reachability.sv
// Top level of the grid tile path reachability block.
`timescale 1ns / 1ps

// Tile cells stream in row-major order, one per beat. The beat with tlast set ends the
// grid and starts the search, during which no input beat is taken: first a sweep
// clears the visited map, one cell a cycle, then a breadth-first fill from the top-left
// cell pops each queued cell, fetches it and reads its tile, then tries each direction
// in turn and, where the tile leaves by that side towards a neighbour inside the grid,
// reads that neighbour and queues it if it is unvisited and its tile connects back.
// When the queue is empty the result beat, path_exists, is registered and offered once
// the output slot is free; the next grid may load while it waits. Row and column counts
// are written on the configuration channel; the user must write them only while the
// block is idle, which the block itself does not enforce. 0 counts as 1 and values
// above the maximum as the maximum.

module grid_tile_path_reachability
    import gtpr_pkg::*;
#(
    parameter int MAX_ROWS    = GTPR_MAX_ROWS,
    parameter int MAX_COLUMNS = GTPR_MAX_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [2:0] tile_code, [7:3] zero
    input  logic                  s_axis_tlast,  // last_cell
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // [0] path_exists, [7:1] zero
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       path_exists;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.load;
    assign m_axis_tdata  = {7'd0, path_exists};

    gtpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gtpr_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_tile_code   (s_axis_tdata[2:0]),
        .i_last_cell   (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_path_exists (path_exists)
    );

endmodule
